// ===== hw/rtl/bdt_pkg.sv =====
// ----------------------------------------------------------------------------
// bdt_pkg: shared types and constants of the breath trigger detector
// Field widths, mode and register codes, and the controller/datapath structs.
// ----------------------------------------------------------------------------
package bdt_pkg;

    // field widths
    localparam int ModeW    = 3;
    localparam int FlowW    = 24;
    localparam int PressW   = 16;
    localparam int OffW     = 10;
    localparam int AccW     = 15;
    localparam int LevelW   = 13;
    localparam int CountW   = 8;
    localparam int SumW     = 32;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 24;

    // flow / 100 by reciprocal: q = (|x| * FlowRecip) >> RecipShift, exact for |x| <= 2^23
    localparam int RecipShift = 30;
    localparam int ProdW      = 2 * FlowW;
    localparam int QuotW      = ProdW - RecipShift;
    localparam logic [FlowW-1:0] FlowRecip = 24'd10737419;

    // gate arithmetic width, wide enough that no gate distance wraps
    localparam int GateW = 20;

    localparam logic [AccW-1:0]   AccMax        = 15'h7FFF;
    localparam logic signed [FlowW-1:0] CpapFlowHi = 24'sd2000;
    localparam logic signed [FlowW-1:0] CpapFlowLo = -24'sd2000;
    localparam logic [CountW-1:0] CpapCountMax  = 8'd200;
    localparam logic [CountW-1:0] CpapCountMin  = 8'd16;
    localparam logic [SumW-1:0]   CpapEndLevel  = 32'd1000;

    // mode codes
    localparam logic [ModeW-1:0] ModeIdle    = 3'd0;
    localparam logic [ModeW-1:0] ModeExh     = 3'd1;
    localparam logic [ModeW-1:0] ModeInh     = 3'd2;
    localparam logic [ModeW-1:0] ModeBoth    = 3'd3;
    localparam logic [ModeW-1:0] ModeCpapIns = 3'd4;
    localparam logic [ModeW-1:0] ModeCpapExh = 3'd5;

    // register indexes
    localparam logic [CfgIdxW-1:0] RegMode       = 3'd0;
    localparam logic [CfgIdxW-1:0] RegInhFlow    = 3'd1;
    localparam logic [CfgIdxW-1:0] RegInhPress   = 3'd2;
    localparam logic [CfgIdxW-1:0] RegExhFlow    = 3'd3;
    localparam logic [CfgIdxW-1:0] RegExhPress   = 3'd4;
    localparam logic [CfgIdxW-1:0] RegNearOff    = 3'd5;
    localparam logic [CfgIdxW-1:0] RegFarOff     = 3'd6;

    localparam logic [OffW-1:0] NearOffRst = 10'd10;
    localparam logic [OffW-1:0] FarOffRst  = 10'd100;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // latch sample, apply restart
        logic mul_flow;   // |flow| * recip
        logic mul_base;   // flow quotient out, |base| * recip
        logic base_quot;  // base quotient out
        logic gate_upd;   // accumulator update + trigger
        logic cpap_upd;   // CPAP sum / count update
        logic div_start;  // start sum / count
        logic div_take;   // quotient ready, set trigger
        logic load_out;   // load output word
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic mode_gate;
        logic mode_cpap;
        logic cnt_ge16;
        logic div_done;
    } t_dp_sts;

endpackage

// ===== hw/rtl/bdt_in_if.sv =====
// ----------------------------------------------------------------------------
// bdt_in_if: sample channel
// valid/ready handshake carrying restart, flow and pressure.
// ----------------------------------------------------------------------------
interface bdt_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 restart;
    logic signed [bdt_pkg::FlowW-1:0]     flow_sample;
    logic signed [bdt_pkg::PressW-1:0]    press_sample;

    modport source (output valid, restart, flow_sample, press_sample, input ready);
    modport sink   (input valid, restart, flow_sample, press_sample, output ready);
endinterface

// ===== hw/rtl/bdt_out_if.sv =====
// ----------------------------------------------------------------------------
// bdt_out_if: result channel
// valid/ready handshake carrying trigger, level and sample count.
// ----------------------------------------------------------------------------
interface bdt_out_if;
    logic                          valid;
    logic                          ready;
    logic                          trigger;
    logic [bdt_pkg::LevelW-1:0]    level;
    logic [bdt_pkg::CountW-1:0]    sample_count;

    modport source (output valid, trigger, level, sample_count, input ready);
    modport sink   (input valid, trigger, level, sample_count, output ready);
endinterface

// ===== hw/rtl/bdt_div.sv =====
// ----------------------------------------------------------------------------
// bdt_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, then a done strobe.
// ----------------------------------------------------------------------------
module bdt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bdt_pkg::SumW-1:0]    i_dividend,
    input  logic [bdt_pkg::CountW-1:0]  i_divisor,
    output logic                        o_done,
    output logic [bdt_pkg::SumW-1:0]    o_quot
);
    localparam int StepW = $clog2(bdt_pkg::SumW);

    logic                        r_busy;
    logic                        r_done;
    logic [StepW-1:0]            r_step;
    logic [bdt_pkg::SumW-1:0]    r_quo;
    logic [bdt_pkg::CountW-1:0]  r_rem;
    logic [bdt_pkg::CountW-1:0]  r_dvsr;

    logic [bdt_pkg::CountW:0]    w_trial;
    logic                        w_fits;

    assign w_trial = {r_rem, r_quo[bdt_pkg::SumW-1]};
    assign w_fits  = (w_trial >= {1'b0, r_dvsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= StepW'(bdt_pkg::SumW - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? bdt_pkg::CountW'(w_trial - {1'b0, r_dvsr})
                            : w_trial[bdt_pkg::CountW-1:0];
            r_quo <= {r_quo[bdt_pkg::SumW-2:0], w_fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

endmodule

// ===== hw/rtl/bdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdt_ctrl: sequencer of the breath trigger detector
// Walks one sample through gate, CPAP or no steps and owns the output valid.
// ----------------------------------------------------------------------------
module bdt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  bdt_pkg::t_dp_sts  i_sts,
    output bdt_pkg::t_dp_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MULF = 4'd1;
    localparam logic [3:0] S_MULB = 4'd2;
    localparam logic [3:0] S_BQ   = 4'd3;
    localparam logic [3:0] S_GATE = 4'd4;
    localparam logic [3:0] S_CPAP = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.mode_gate)      n_state = S_MULF;
                    else if (i_sts.mode_cpap) n_state = S_CPAP;
                    else                      n_state = S_DONE;
                end
            end
            S_MULF: begin
                o_cmd.mul_flow = 1'b1;
                n_state        = S_MULB;
            end
            S_MULB: begin
                o_cmd.mul_base = 1'b1;
                n_state        = S_BQ;
            end
            S_BQ: begin
                o_cmd.base_quot = 1'b1;
                n_state         = S_GATE;
            end
            S_GATE: begin
                o_cmd.gate_upd = 1'b1;
                n_state        = S_DONE;
            end
            S_CPAP: begin
                o_cmd.cpap_upd = 1'b1;
                n_state        = S_CHK;
            end
            S_CHK: begin
                // average only counts once enough samples are in
                if (i_sts.cnt_ge16) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output slot
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("sample accepted but sequencer stayed idle");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result word raised outside the done step");

endmodule

// ===== hw/rtl/bdt_dp.sv =====
// ----------------------------------------------------------------------------
// bdt_dp: datapath of the breath trigger detector
// Config registers, flow scaling, gate accumulators, CPAP sum/count, divider.
// ----------------------------------------------------------------------------
module bdt_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bdt_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [bdt_pkg::CfgDataW-1:0]      i_cfg_data,
    input  bdt_pkg::t_dp_cmd                  i_cmd,
    output bdt_pkg::t_dp_sts                  o_sts,
    input  logic                              i_restart,
    input  logic signed [bdt_pkg::FlowW-1:0]  i_flow,
    input  logic signed [bdt_pkg::PressW-1:0] i_press,
    output logic                              o_trigger,
    output logic [bdt_pkg::LevelW-1:0]        o_level,
    output logic [bdt_pkg::CountW-1:0]        o_sample_count
);
    // config
    logic [bdt_pkg::ModeW-1:0]         r_mode;
    logic signed [bdt_pkg::FlowW-1:0]  r_inh_flow;
    logic signed [bdt_pkg::PressW-1:0] r_inh_press;
    logic signed [bdt_pkg::FlowW-1:0]  r_exh_flow;
    logic signed [bdt_pkg::PressW-1:0] r_exh_press;
    logic [bdt_pkg::OffW-1:0]          r_near;
    logic [bdt_pkg::OffW-1:0]          r_far;

    // state
    logic [bdt_pkg::AccW-1:0]          r_flow_acc;
    logic [bdt_pkg::AccW-1:0]          r_press_acc;
    logic signed [bdt_pkg::SumW-1:0]   r_sum;
    logic [bdt_pkg::CountW-1:0]        r_count;
    logic                              r_trig;

    // per-sample working registers
    logic signed [bdt_pkg::FlowW-1:0]  r_flow;
    logic signed [bdt_pkg::PressW-1:0] r_press;
    logic [bdt_pkg::ProdW-1:0]         r_prod;
    logic                              r_prod_neg;
    logic signed [bdt_pkg::QuotW-1:0]  r_fq;
    logic signed [bdt_pkg::QuotW-1:0]  r_bq;

    // output word
    logic                              r_out_trig;
    logic [bdt_pkg::LevelW-1:0]        r_out_level;
    logic [bdt_pkg::CountW-1:0]        r_out_count;

    function automatic logic [bdt_pkg::FlowW-1:0] f_abs_flow(
        logic signed [bdt_pkg::FlowW-1:0] x);
        return x[bdt_pkg::FlowW-1] ? $unsigned(-x) : $unsigned(x);
    endfunction

    // one accumulator step: clear outside gate, add clamped excess, saturate
    function automatic logic [bdt_pkg::AccW-1:0] f_gate_step(
        logic [bdt_pkg::AccW-1:0]         acc,
        logic signed [bdt_pkg::GateW-1:0] excess,
        logic [bdt_pkg::OffW-1:0]         span);
        logic [bdt_pkg::OffW-1:0] add;
        logic [bdt_pkg::AccW:0]   total;
        if (excess < 0) return '0;
        if (excess > $signed({{(bdt_pkg::GateW-bdt_pkg::OffW){1'b0}}, span})) add = span;
        else add = excess[bdt_pkg::OffW-1:0];
        total = {1'b0, acc} + {{(bdt_pkg::AccW+1-bdt_pkg::OffW){1'b0}}, add};
        return (total > {1'b0, bdt_pkg::AccMax}) ? bdt_pkg::AccMax
                                                 : total[bdt_pkg::AccW-1:0];
    endfunction

    // ---------------- config writes ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= bdt_pkg::ModeIdle;
            r_inh_flow  <= '0;
            r_inh_press <= '0;
            r_exh_flow  <= '0;
            r_exh_press <= '0;
            r_near      <= bdt_pkg::NearOffRst;
            r_far       <= bdt_pkg::FarOffRst;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bdt_pkg::RegMode:     r_mode      <= i_cfg_data[bdt_pkg::ModeW-1:0];
                bdt_pkg::RegInhFlow:  r_inh_flow  <= $signed(i_cfg_data);
                bdt_pkg::RegInhPress: r_inh_press <= $signed(i_cfg_data[bdt_pkg::PressW-1:0]);
                bdt_pkg::RegExhFlow:  r_exh_flow  <= $signed(i_cfg_data);
                bdt_pkg::RegExhPress: r_exh_press <= $signed(i_cfg_data[bdt_pkg::PressW-1:0]);
                bdt_pkg::RegNearOff:  r_near      <= i_cfg_data[bdt_pkg::OffW-1:0];
                bdt_pkg::RegFarOff:   r_far       <= i_cfg_data[bdt_pkg::OffW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow scaling ----------------
    logic                              w_inh;
    logic signed [bdt_pkg::FlowW-1:0]  w_base;
    logic [bdt_pkg::QuotW-1:0]         w_qmag;
    logic signed [bdt_pkg::QuotW-1:0]  w_quot;

    assign w_inh  = (r_mode == bdt_pkg::ModeInh);
    assign w_base = w_inh ? r_inh_flow : r_exh_flow;
    assign w_qmag = r_prod[bdt_pkg::ProdW-1:bdt_pkg::RecipShift];
    assign w_quot = r_prod_neg ? -$signed(w_qmag) : $signed(w_qmag);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_flow  <= i_flow;
            r_press <= i_press;
        end
        if (i_cmd.mul_flow) begin
            r_prod     <= {{bdt_pkg::FlowW{1'b0}}, f_abs_flow(r_flow)}
                        * {{bdt_pkg::FlowW{1'b0}}, bdt_pkg::FlowRecip};
            r_prod_neg <= r_flow[bdt_pkg::FlowW-1];
        end
        if (i_cmd.mul_base) begin
            r_fq       <= w_quot;
            r_prod     <= {{bdt_pkg::FlowW{1'b0}}, f_abs_flow(w_base)}
                        * {{bdt_pkg::FlowW{1'b0}}, bdt_pkg::FlowRecip};
            r_prod_neg <= w_base[bdt_pkg::FlowW-1];
        end
        if (i_cmd.base_quot) begin
            r_bq <= w_quot;
        end
    end

    // ---------------- gate accumulators ----------------
    localparam int QExt = bdt_pkg::GateW - bdt_pkg::QuotW;
    localparam int PExt = bdt_pkg::GateW - bdt_pkg::PressW;

    logic [bdt_pkg::OffW-1:0]          w_span;
    logic signed [bdt_pkg::GateW-1:0]  w_near;
    logic signed [bdt_pkg::GateW-1:0]  w_fq;
    logic signed [bdt_pkg::GateW-1:0]  w_bq;
    logic signed [bdt_pkg::GateW-1:0]  w_pb;
    logic signed [bdt_pkg::GateW-1:0]  w_pr;
    logic signed [bdt_pkg::GateW-1:0]  w_dist_f;
    logic signed [bdt_pkg::GateW-1:0]  w_dist_p;
    logic [bdt_pkg::AccW-1:0]          w_flow_acc;
    logic [bdt_pkg::AccW-1:0]          w_press_acc;
    logic [bdt_pkg::AccW:0]            w_gate_total;
    logic [bdt_pkg::LevelW-1:0]        w_gate_level;
    logic                              w_gate_trig;

    assign w_span = (r_far > r_near) ? (r_far - r_near) : '0;
    assign w_near = $signed({{(bdt_pkg::GateW-bdt_pkg::OffW){1'b0}}, r_near});
    assign w_fq   = {{QExt{r_fq[bdt_pkg::QuotW-1]}}, r_fq};
    assign w_bq   = {{QExt{r_bq[bdt_pkg::QuotW-1]}}, r_bq};
    assign w_pb   = w_inh ? {{PExt{r_inh_press[bdt_pkg::PressW-1]}}, r_inh_press}
                          : {{PExt{r_exh_press[bdt_pkg::PressW-1]}}, r_exh_press};
    assign w_pr   = {{PExt{r_press[bdt_pkg::PressW-1]}}, r_press};

    // inhale: flow rises above its gate, pressure drops below its gate
    assign w_dist_f = w_inh ? (w_fq - (w_bq + w_near)) : ((w_bq - w_near) - w_fq);
    assign w_dist_p = w_inh ? ((w_pb - w_near) - w_pr) : (w_pr - (w_pb + w_near));

    assign w_flow_acc   = f_gate_step(r_flow_acc, w_dist_f, w_span);
    assign w_press_acc  = f_gate_step(r_press_acc, w_dist_p, w_span);
    assign w_gate_total = {1'b0, w_flow_acc} + {1'b0, w_press_acc};
    assign w_gate_level = w_gate_total[bdt_pkg::AccW:3];
    assign w_gate_trig  = (w_gate_level >
                           {{(bdt_pkg::LevelW-bdt_pkg::OffW-1){1'b0}}, w_span, 1'b0});

    // ---------------- CPAP sum / count ----------------
    logic                              w_cpap_ins;
    logic                              w_cpap_clr;
    logic signed [bdt_pkg::FlowW-1:0]  w_flow_rnd;
    logic signed [bdt_pkg::FlowW-1:0]  w_flow_div8;
    logic signed [bdt_pkg::SumW-1:0]   w_sum_rnd;
    logic signed [bdt_pkg::SumW-1:0]   w_sum_div8;
    logic [bdt_pkg::SumW-1:0]          w_sum_abs;

    assign w_cpap_ins = (r_mode == bdt_pkg::ModeCpapIns);
    assign w_cpap_clr = w_cpap_ins ? (r_flow > bdt_pkg::CpapFlowHi)
                                   : (r_flow < bdt_pkg::CpapFlowLo);
    // exhale side truncates toward zero: bias negatives by 7 before the shift
    assign w_flow_rnd  = w_cpap_ins ? r_flow
                       : (r_flow + $signed({{(bdt_pkg::FlowW-3){1'b0}},
                                            {3{r_flow[bdt_pkg::FlowW-1]}}}));
    assign w_flow_div8 = w_flow_rnd >>> 3;
    assign w_sum_rnd   = w_cpap_ins ? r_sum
                       : (r_sum + $signed({{(bdt_pkg::SumW-3){1'b0}},
                                           {3{r_sum[bdt_pkg::SumW-1]}}}));
    assign w_sum_div8  = w_sum_rnd >>> 3;
    assign w_sum_abs   = r_sum[bdt_pkg::SumW-1] ? $unsigned(-r_sum) : $unsigned(r_sum);

    // ---------------- divider ----------------
    logic                        w_div_done;
    logic [bdt_pkg::SumW-1:0]    w_div_quot;

    bdt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_sum_abs),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // ---------------- state update ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_acc  <= '0;
            r_press_acc <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_trig      <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_trig <= 1'b0;
                if (i_restart) begin
                    r_flow_acc  <= '0;
                    r_press_acc <= '0;
                    r_sum       <= '0;
                    r_count     <= '0;
                end
            end
            if (i_cmd.gate_upd) begin
                r_flow_acc  <= w_flow_acc;
                r_press_acc <= w_press_acc;
                r_trig      <= w_gate_trig;
            end
            if (i_cmd.cpap_upd) begin
                if (w_cpap_clr) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else if (r_count < bdt_pkg::CpapCountMax) begin
                    r_count <= r_count + 1'b1;
                    r_sum   <= r_sum + {{(bdt_pkg::SumW-bdt_pkg::FlowW)
                                        {w_flow_div8[bdt_pkg::FlowW-1]}}, w_flow_div8};
                end else begin
                    r_count <= r_count >> 3;
                    r_sum   <= w_sum_div8;
                end
            end
            if (i_cmd.div_take) begin
                // sign of the sum decides alone when it already lies on the far side
                r_trig <= (w_cpap_ins ? r_sum[bdt_pkg::SumW-1] : !r_sum[bdt_pkg::SumW-1])
                       || (w_div_quot < bdt_pkg::CpapEndLevel);
            end
        end
    end

    // ---------------- output word ----------------
    logic [bdt_pkg::AccW:0] w_acc_total;

    assign w_acc_total = {1'b0, r_flow_acc} + {1'b0, r_press_acc};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_trig  <= r_trig;
            r_out_level <= w_acc_total[bdt_pkg::AccW:3];
            r_out_count <= r_count;
        end
    end

    assign o_trigger      = r_out_trig;
    assign o_level        = r_out_level;
    assign o_sample_count = r_out_count;

    assign o_sts.mode_gate = (r_mode == bdt_pkg::ModeExh) || (r_mode == bdt_pkg::ModeInh);
    assign o_sts.mode_cpap = (r_mode == bdt_pkg::ModeCpapIns)
                          || (r_mode == bdt_pkg::ModeCpapExh);
    assign o_sts.cnt_ge16  = (r_count >= bdt_pkg::CpapCountMin);
    assign o_sts.div_done  = w_div_done;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bdt_pkg::CpapCountMax)
        else $error("CPAP sample count above its limit");

endmodule

// ===== hw/rtl/breath_trigger_detector_unit.sv =====
// ----------------------------------------------------------------------------
// breath_trigger_detector_unit: breath trigger detector top level
// A new sample is taken only after the result word of the previous one has
// been loaded; the gate modes walk the multiply and accumulator steps, the
// CPAP modes run the 32-step divider once 16 samples are counted, which sets
// the CPAP rate; idle and both modes go straight to the result word.
// Reset (sync, active low) clears accumulators, CPAP sum/count and loads the
// register reset values.
// ----------------------------------------------------------------------------
module breath_trigger_detector_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bdt_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [bdt_pkg::CfgDataW-1:0]      i_cfg_data,
    bdt_in_if.sink                            i_in,
    bdt_out_if.source                         o_out
);
    bdt_pkg::t_dp_cmd w_cmd;
    bdt_pkg::t_dp_sts w_sts;
    logic             w_in_ready;
    logic             w_out_valid;

    // Sequencer: takes a word only when idle, then steps it through the gate
    // path (two reciprocal multiplies, one accumulator update), the CPAP path
    // (sum/count update, optional divide) or no path at all. The result word
    // sits in an output register, so a new sample is taken while it waits.
    bdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Datapath: config registers, detector state, divider, output word.
    bdt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_restart      (i_in.restart),
        .i_flow         (i_in.flow_sample),
        .i_press        (i_in.press_sample),
        .o_trigger      (o_out.trigger),
        .o_level        (o_out.level),
        .o_sample_count (o_out.sample_count)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

endmodule
